// ----- rtl/rhsv_pkg.sv -----
// Shared widths, types and the divider step function for the RGB to HSV core.
package rhsv_pkg;

   localparam int CHAN_W  = 8;
   localparam int DIFF_W  = 11;
   localparam int NUM_W   = 19;
   localparam int QUOT_W  = 8;
   localparam int DIV_STG = 4;
   localparam int PIPE_STG = 2 + DIV_STG;

   typedef struct packed {
      logic             qbit;
      logic [NUM_W-1:0] rem;
   } div_res_type;

   function automatic div_res_type div_bit(input logic [NUM_W-1:0] n,
                                           input logic [NUM_W-1:0] dsh);
      div_res_type res;
      if (n >= dsh) begin
         res.qbit = 1'b1;
         res.rem  = n - dsh;
      end else begin
         res.qbit = 1'b0;
         res.rem  = n;
      end
      return res;
   endfunction

endpackage

// ----- rtl/rgb_to_hsv_pixel_core.sv -----
// RGB to HSV pixel converter, top level.
// Streaming pixel converter: one 24-bit pixel in on req_*, one HSV result out on rsp_*.
// req_tdata holds the first, middle and third channel bytes from the low end; the
// middle byte is green, and csr_wdata (written when csr_we is high) picks whether the
// first byte is red (0) or blue (1). rsp_tdata holds hue, saturation and brightness.
// tlast marks the last pixel of a frame and is carried through to the result.
// Six register stages: one for the min/max and sector pick, one for the hue and
// saturation numerators and divisors, and four of a pipelined divider (two quotient
// bits each) shared in form by hue and saturation. Throughput is one pixel per clock
// while rsp_tready stays high. Each stage holds its own valid bit, so when
// rsp_tready is low the results stay put and earlier stages keep filling any bubbles
// before req_tready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the channel order to RGB.
// Change csr_wdata only while no pixel is in flight.
module rgb_to_hsv_pixel_core
   import rhsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // chan_first, chan_middle, chan_third
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // hue, saturation, brightness
   output logic        rsp_tlast
);

   logic                order_ff;
   logic [PIPE_STG-1:0] v_ff;
   logic [PIPE_STG:0]   rdy;

   // stage 1
   logic [CHAN_W-1:0] mx_ff, d1_ff, part_ff;
   logic [2:0]        base_ff;
   logic              add_ff, last1_ff;

   // stage 2
   logic [NUM_W-1:0]  nh_ff, ns_ff;
   logic [DIFF_W-1:0] dh_ff, ds_ff;
   logic [CHAN_W-1:0] mx2_ff;
   logic              last2_ff;

   // divider sidebands
   logic [CHAN_W-1:0] bright_ff [DIV_STG];
   logic              last_ff   [DIV_STG];

   logic [CHAN_W-1:0] r, g, b, mx_in, mn_in, d_in, part_in;
   logic [2:0]        base_in;
   logic              add_in;
   logic [DIFF_W-1:0] bd, num, dz;
   logic [NUM_W-1:0]  nh_in, ns_in;
   logic [DIFF_W-1:0] dh_in, ds_in;
   logic [DIV_STG-1:0] div_ld;
   logic [QUOT_W-1:0] hue_q, sat_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
      end else if (csr_we) begin
         order_ff <= csr_wdata;
      end
   end

   always_comb begin
      rdy[PIPE_STG] = rsp_tready;
      for (int k = PIPE_STG - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_tready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < PIPE_STG; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // min, max and hue sector
   always_comb begin
      g = req_tdata[15:8];
      if (order_ff) begin
         r = req_tdata[23:16];
         b = req_tdata[7:0];
      end else begin
         r = req_tdata[7:0];
         b = req_tdata[23:16];
      end
      mx_in = r;
      mn_in = r;
      if (g > mx_in) mx_in = g;
      if (b > mx_in) mx_in = b;
      if (g < mn_in) mn_in = g;
      if (b < mn_in) mn_in = b;
      d_in = mx_in - mn_in;
      if (r == mx_in) begin
         if (g == mn_in) begin
            base_in = 3'd5; part_in = mx_in - b; add_in = 1'b1;
         end else begin
            base_in = 3'd1; part_in = mx_in - g; add_in = 1'b0;
         end
      end else if (g == mx_in) begin
         if (b == mn_in) begin
            base_in = 3'd1; part_in = mx_in - r; add_in = 1'b1;
         end else begin
            base_in = 3'd3; part_in = mx_in - b; add_in = 1'b0;
         end
      end else if (r == mn_in) begin
         base_in = 3'd3; part_in = mx_in - g; add_in = 1'b1;
      end else begin
         base_in = 3'd5; part_in = mx_in - r; add_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && req_tvalid) begin
         mx_ff    <= mx_in;
         d1_ff    <= d_in;
         part_ff  <= part_in;
         base_ff  <= base_in;
         add_ff   <= add_in;
         last1_ff <= req_tlast;
      end
   end

   // numerators 255*num and 255*d, divisors 6*d and max; zero divisors become 1
   always_comb begin
      dz = {3'b0, d1_ff};
      case (base_ff)
         3'd1:    bd = dz;
         3'd3:    bd = (dz << 1) + dz;
         3'd5:    bd = (dz << 2) + dz;
         default: bd = '0;
      endcase
      num   = add_ff ? bd + {3'b0, part_ff} : bd - {3'b0, part_ff};
      nh_in = {num, 8'b0} - {8'b0, num};
      ns_in = {3'b0, d1_ff, 8'b0} - {11'b0, d1_ff};
      dh_in = (d1_ff == '0) ? DIFF_W'(1) : (dz << 2) + (dz << 1);
      ds_in = (mx_ff == '0) ? DIFF_W'(1) : {3'b0, mx_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy[1] && v_ff[0]) begin
         nh_ff    <= nh_in;
         ns_ff    <= ns_in;
         dh_ff    <= dh_in;
         ds_ff    <= ds_in;
         mx2_ff   <= mx_ff;
         last2_ff <= last1_ff;
      end
   end

   always_comb begin
      for (int s = 0; s < DIV_STG; s++) begin
         div_ld[s] = rdy[2+s] && v_ff[1+s];
      end
   end

   always_ff @(posedge clock) begin
      if (div_ld[0]) begin
         bright_ff[0] <= mx2_ff;
         last_ff[0]   <= last2_ff;
      end
      for (int s = 1; s < DIV_STG; s++) begin
         if (div_ld[s]) begin
            bright_ff[s] <= bright_ff[s-1];
            last_ff[s]   <= last_ff[s-1];
         end
      end
   end

   rhsv_div u_hue_div (
      .clock (clock),
      .ld    (div_ld),
      .n_in  (nh_ff),
      .d_in  (dh_ff),
      .q_out (hue_q)
   );

   rhsv_div u_sat_div (
      .clock (clock),
      .ld    (div_ld),
      .n_in  (ns_ff),
      .d_in  (ds_ff),
      .q_out (sat_q)
   );

   assign rsp_tvalid = v_ff[PIPE_STG-1];
   assign rsp_tdata  = {bright_ff[DIV_STG-1], sat_q, hue_q};
   assign rsp_tlast  = last_ff[DIV_STG-1];

endmodule

// ----- rtl/rhsv_div.sv -----
// Pipelined restoring divider, two quotient bits per stage, eight-bit quotient.
module rhsv_div
   import rhsv_pkg::*;
(
   input  logic                clock,
   input  logic [DIV_STG-1:0]  ld,
   input  logic [NUM_W-1:0]    n_in,
   input  logic [DIFF_W-1:0]   d_in,
   output logic [QUOT_W-1:0]   q_out
);

   logic [NUM_W-1:0]  n_ff [DIV_STG];
   logic [DIFF_W-1:0] d_ff [DIV_STG];
   logic [QUOT_W-1:0] q_ff [DIV_STG];

   for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
      localparam int Hi = QUOT_W - 1 - 2 * s;
      logic [NUM_W-1:0]  n_src;
      logic [DIFF_W-1:0] d_src;
      logic [QUOT_W-1:0] q_src;
      logic [NUM_W-1:0]  d_ext;
      div_res_type       st_a;
      div_res_type       st_b;

      if (s == 0) begin : g_first
         assign n_src = n_in;
         assign d_src = d_in;
         assign q_src = '0;
      end else begin : g_next
         assign n_src = n_ff[s-1];
         assign d_src = d_ff[s-1];
         assign q_src = q_ff[s-1];
      end

      assign d_ext = {{(NUM_W-DIFF_W){1'b0}}, d_src};
      assign st_a  = div_bit(n_src, d_ext << Hi);
      assign st_b  = div_bit(st_a.rem, d_ext << (Hi - 1));

      always_ff @(posedge clock) begin
         if (ld[s]) begin
            n_ff[s] <= st_b.rem;
            d_ff[s] <= d_src;
            q_ff[s] <= {q_src[QUOT_W-3:0], st_a.qbit, st_b.qbit};
         end
      end
   end

   assign q_out = q_ff[DIV_STG-1];

endmodule

// ----- rtl/rhsv_checker.sv -----
// Port-level checks for the RGB to HSV core, bound to the top level.
module rhsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled transfer changed");

   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:16] == 8'd0 |-> rsp_tdata[15:0] == 16'd0)
      else $error("black pixel with non-zero hue or saturation");

   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:8] == 8'd0 |-> rsp_tdata[7:0] == 8'd0)
      else $error("gray pixel with non-zero hue");

endmodule

bind rgb_to_hsv_pixel_core rhsv_checker u_rhsv_checker (.*);

// ----- verif/rgb_to_hsv_pixel_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the RGB to HSV pixel core: directed corners, then random pixels.
module rgb_to_hsv_pixel_core_test;
   import rhsv_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = PIPE_STG + 4;
   localparam int NUM_CORNERS = 13;

   // {last, third, middle, first}
   localparam logic [24:0] CORNER_PIXELS [NUM_CORNERS] = '{
      25'h0000000, 25'h1FFFFFF, 25'h0808080, 25'h00000FF, 25'h000FF00,
      25'h1FF0000, 25'h000FFFF, 25'h0FFFF00, 25'h0FF00FF, 25'h00100FF,
      25'h0000001, 25'h1FEFEFF, 25'h05AC811
   };

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic       last;
   } hsv_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // chan_first, chan_middle, chan_third
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // hue, saturation, brightness
   logic        rsp_tlast;

   hsv_result_type pending_hsv [$];
   bit          bgr_order;
   bit          idle_en = 1'b1;
   int          mismatches;
   int          pixels_sent;
   int          frames_sent;
   int          results_seen;
   int          quiet_cycles;

   rgb_to_hsv_pixel_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic hsv_result_type predict_hsv(bit order, logic [7:0] first,
                                                  logic [7:0] middle, logic [7:0] third,
                                                  logic last);
      hsv_result_type res;
      int unsigned red, green, blue, hi, lo, span, base, part, num, h;
      bit          up;
      red   = order ? third : first;
      blue  = order ? first : third;
      green = middle;
      hi = red;
      lo = red;
      if (green > hi) hi = green;
      if (blue > hi) hi = blue;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
      span = hi - lo;
      res.brightness = hi[7:0];
      res.saturation = (hi == 0) ? 8'd0 : 8'((255 * span) / hi);
      res.last = last;
      if (span == 0) begin
         res.hue = 8'd0;
         return res;
      end
      if (red == hi) begin
         if (green == lo) begin
            base = 5; part = hi - blue; up = 1'b1;
         end else begin
            base = 1; part = hi - green; up = 1'b0;
         end
      end else if (green == hi) begin
         if (blue == lo) begin
            base = 1; part = hi - red; up = 1'b1;
         end else begin
            base = 3; part = hi - blue; up = 1'b0;
         end
      end else if (red == lo) begin
         base = 3; part = hi - green; up = 1'b1;
      end else begin
         base = 5; part = hi - red; up = 1'b0;
      end
      num = up ? base * span + part : base * span - part;
      h = (255 * num) / (6 * span);
      if (h > 255) h = 255;
      res.hue = h[7:0];
      return res;
   endfunction

   // ties and extremes come up often enough to hit every sector boundary
   function automatic logic [7:0] pick_channel(logic [7:0] tie);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return tie;
      if (roll < 20) return 8'd0;
      if (roll < 25) return 8'd255;
      if (roll < 28) return tie + 8'd1;
      if (roll < 31) return tie - 8'd1;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_pixel(logic [7:0] first, logic [7:0] middle, logic [7:0] third,
                             logic last);
      if (idle_en && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {third, middle, first};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pending_hsv.push_back(predict_hsv(bgr_order, first, middle, third, last));
      pixels_sent++;
      if (last) frames_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_hsv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_channel_order(bit order);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= order;
      @(posedge clock);
      csr_we    <= 1'b0;
      bgr_order = order;
      @(posedge clock);
   endtask

   task automatic test_corners();
      for (int i = 0; i < NUM_CORNERS; i++)
         send_pixel(CORNER_PIXELS[i][7:0], CORNER_PIXELS[i][15:8],
                    CORNER_PIXELS[i][23:16], CORNER_PIXELS[i][24]);
   endtask

   task automatic test_random_pixels(int count, bit order, bit idling);
      logic [7:0] first, middle, third;
      set_channel_order(order);
      idle_en = idling;
      for (int i = 0; i < count; i++) begin
         first  = 8'($urandom_range(255));
         middle = pick_channel(first);
         third  = pick_channel($urandom_range(1) ? first : middle);
         send_pixel(first, middle, third, $urandom_range(15) == 0);
      end
      idle_en = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_tready <= !idle_en || $urandom_range(99) >= 14;
   end

   task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      hsv_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_hsv.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h/%b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_hsv.pop_front();
            report_field("hue", want.hue, rsp_tdata[7:0]);
            report_field("saturation", want.saturation, rsp_tdata[15:8]);
            report_field("brightness", want.brightness, rsp_tdata[23:16]);
            report_field("tlast", {7'd0, want.last}, {7'd0, rsp_tlast});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, pending_hsv.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      set_channel_order(1'b1);
      test_corners();
      test_random_pixels(400, 1'b0, 1'b1);
      test_random_pixels(300, 1'b1, 1'b1);
      test_random_pixels(300, 1'b0, 1'b0);
      wait_idle();
      $display("%0d pixels in %0d frames, %0d results checked", pixels_sent, frames_sent,
               results_seen);
      $display("corner colours and random pixels in RGB and BGR order, with and without stalls");
      if (mismatches == 0 && pending_hsv.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
